@@ hw/rtl/afd_pkg.sv @@
`timescale 1ns / 1ps
package afd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 2;

  // result tdata: 34 payload bits padded to whole bytes
  localparam int unsigned OutDataW = 40;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_OWN_ID         = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BROADCAST_ID   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE_ONE = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE_TWO = 2'd3;

  // frame status codes
  localparam logic [StatusW-1:0] STATUS_OK           = 2'd0;
  localparam logic [StatusW-1:0] STATUS_BAD_CHECKSUM = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NOT_ADDR     = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] own_id;
    logic [ByteW-1:0] broadcast_id;
    logic [ByteW-1:0] start_byte_one;
    logic [ByteW-1:0] start_byte_two;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0]   data_three;
    logic [ByteW-1:0]   data_two;
    logic [ByteW-1:0]   data_one;
    logic [ByteW-1:0]   msg_type;
    logic [StatusW-1:0] frame_status;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

@@ hw/rtl/addressed_frame_deframer_core.sv @@
`timescale 1ns / 1ps
// channel   | ports                          | contents
// ----------+--------------------------------+------------------------------------
// input     | in_tvalid in_tready in_tdata   | one received byte
// result    | out_tvalid out_tready out_tdata| status, type and data of one frame
// config    | cfg_we cfg_index cfg_wdata     | own id, broadcast id, marker bytes
//
// one byte is taken every cycle while the skid entry is free; the parser state
// advances per byte taken; a finished frame is registered in the output stage.
// a two-entry output stage keeps input flowing while a result waits; input
// stalls only when both entries are full.
// reset (synchronous, active low) returns to marker hunting and empties output.
module addressed_frame_deframer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [afd_pkg::ByteW-1:0]      in_tdata,   // [7:0] rx_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [1:0] frame_status, [9:2] msg_type, [17:10] data_one, [25:18] data_two,
  // [33:26] data_three, [39:34] zero
  output logic [afd_pkg::OutDataW-1:0]   out_tdata,
  input  logic                           cfg_we,
  input  logic [afd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [afd_pkg::ByteW-1:0]      cfg_wdata
);
  import afd_pkg::*;

  cfg_t    cfg;
  logic    byte_en;
  logic    res_en;
  result_t res;
  result_t out_res;
  logic    space_ok;

  assign byte_en = in_tvalid && in_tready;
  assign in_tready = space_ok;

  afd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  afd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .byte_en (byte_en),
    .rx_byte (in_tdata),
    .res_en  (res_en),
    .res     (res)
  );

  afd_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_en    (res_en),
    .res       (res),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {{(OutDataW - ResultW){1'b0}}, out_res};

endmodule

@@ hw/rtl/afd_cfg_regs.sv @@
`timescale 1ns / 1ps
module afd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [afd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [afd_pkg::ByteW-1:0]     cfg_wdata,
  output afd_pkg::cfg_t                 cfg
);
  import afd_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id         <= '0;
      cfg_r.broadcast_id   <= '1;
      cfg_r.start_byte_one <= '0;
      cfg_r.start_byte_two <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ID:         cfg_r.own_id         <= cfg_wdata;
        CFG_BROADCAST_ID:   cfg_r.broadcast_id   <= cfg_wdata;
        CFG_START_BYTE_ONE: cfg_r.start_byte_one <= cfg_wdata;
        CFG_START_BYTE_TWO: cfg_r.start_byte_two <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/afd_parser.sv @@
`timescale 1ns / 1ps
module afd_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  afd_pkg::cfg_t             cfg,
  input  logic                      byte_en,
  input  logic [afd_pkg::ByteW-1:0] rx_byte,
  output logic                      res_en,
  output afd_pkg::result_t          res
);
  import afd_pkg::*;

  localparam int unsigned NumFields = 5;
  localparam int unsigned IdxW      = 3;

  typedef enum logic [1:0] {
    HUNT_ONE = 2'd0,
    HUNT_TWO = 2'd1,
    COLLECT  = 2'd2
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [ByteW-1:0] xor_r, xor_nxt;
  logic [ByteW-1:0] fields_r [NumFields];
  logic            store_en;
  logic            frame_end;
  logic [ByteW-1:0] dest;

  assign frame_end = (phase_r == COLLECT) && (idx_r >= IdxW'(NumFields));
  assign store_en  = byte_en && (phase_r == COLLECT) && !frame_end;
  assign dest      = fields_r[0];

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    xor_nxt   = xor_r;
    case (phase_r)
      HUNT_TWO: begin
        if (rx_byte == cfg.start_byte_two) begin
          phase_nxt = COLLECT;
          idx_nxt   = '0;
          xor_nxt   = '0;
        end else if (rx_byte == cfg.start_byte_one) begin
          phase_nxt = HUNT_TWO;
        end else begin
          phase_nxt = HUNT_ONE;
        end
      end
      COLLECT: begin
        if (frame_end) begin
          phase_nxt = HUNT_ONE;
          idx_nxt   = '0;
          xor_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
          xor_nxt = xor_r ^ rx_byte;
        end
      end
      default: begin
        // also covers the unused phase code
        phase_nxt = (rx_byte == cfg.start_byte_one) ? HUNT_TWO : HUNT_ONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= HUNT_ONE;
      idx_r   <= '0;
      xor_r   <= '0;
    end else if (byte_en) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      xor_r   <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      fields_r[idx_r] <= rx_byte;
    end
  end

  // checksum mismatch wins over a foreign destination
  always_comb begin
    res.msg_type   = fields_r[1];
    res.data_one   = fields_r[2];
    res.data_two   = fields_r[3];
    res.data_three = fields_r[4];
    if (rx_byte != xor_r) begin
      res.frame_status = STATUS_BAD_CHECKSUM;
    end else if ((dest != cfg.broadcast_id) && (dest != cfg.own_id)) begin
      res.frame_status = STATUS_NOT_ADDR;
    end else begin
      res.frame_status = STATUS_OK;
    end
  end

  assign res_en = byte_en && frame_end;

endmodule

@@ hw/rtl/afd_out_skid.sv @@
`timescale 1ns / 1ps
module afd_out_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_en,
  input  afd_pkg::result_t res,
  output logic             space_ok,
  output logic             out_valid,
  input  logic             out_ready,
  output afd_pkg::result_t out_res
);
  import afd_pkg::*;

  logic    main_vld_r, skid_vld_r;
  result_t main_r, skid_r;
  logic    pop;

  assign pop      = main_vld_r && out_ready;
  assign space_ok = !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!main_vld_r || pop) begin
        main_vld_r <= skid_vld_r || res_en;
        skid_vld_r <= skid_vld_r && res_en;
      end else if (res_en) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_vld_r || pop) begin
      main_r <= skid_vld_r ? skid_r : res;
      if (skid_vld_r && res_en) begin
        skid_r <= res;
      end
    end else if (res_en) begin
      skid_r <= res;
    end
  end

  assign out_valid = main_vld_r;
  assign out_res   = main_r;

endmodule
